// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers, included by the allocator unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`define ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("assertion failed: label");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_DELAY(label, clk, rst_n, ante, n, cons)
`endif
`endif

// ----- hw/rtl/irsa_pkg.sv -----
package irsa_pkg;

  localparam int ENTRY_W = 6;
  localparam int SLOT_W  = 3;
  localparam int CNT_W   = 4;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_HEAP  = 3'd2,
    ST_ORDER = 3'd3,
    ST_NONE  = 3'd4
  } status_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture request and read slot entry
    logic exec;   // evaluate, write back, emit result
  } irsa_cmd_t;

endpackage

// ----- hw/rtl/irsa_ctrl.sv -----
module irsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output irsa_pkg::irsa_cmd_t cmd
);
  import irsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign cmd.load = start && (state_r == S_IDLE);
  assign cmd.exec = (state_r == S_EXEC);

endmodule

// ----- hw/rtl/irsa_dpath.sv -----
module irsa_dpath #(
  parameter int RING_ENTRIES = 64,
  parameter int MAX_SLOTS    = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irsa_pkg::irsa_cmd_t           cmd,
  input  logic                          cfg_we,
  input  logic [irsa_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                          in_action,
  input  logic [irsa_pkg::SLOT_W-1:0]   in_slot,
  input  logic [irsa_pkg::ENTRY_W-1:0]  in_entry_index,
  input  logic                          in_in_pool,
  input  logic                          in_present,
  output logic                          out_valid,
  output irsa_pkg::status_t             out_status,
  output logic [irsa_pkg::ENTRY_W-1:0]  out_granted_index
);
  import irsa_pkg::*;

  localparam int PW   = $clog2(RING_ENTRIES);
  localparam int SIW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SW   = ((PW > CNT_W) ? PW : CNT_W) + 1;
  localparam int CW   = (PW > ENTRY_W) ? PW : ENTRY_W;
  localparam int NRED = (RING_ENTRIES + 14) / RING_ENTRIES;

  // (pos + stride) mod RING_ENTRIES, pos already below RING_ENTRIES
  function automatic logic [PW-1:0] advance(input logic [PW-1:0] pos,
                                            input logic [CNT_W-1:0] stride);
    logic [SW-1:0] s;
    s = SW'(pos) + SW'(stride);
    for (int i = 0; i < NRED; i++) begin
      if (s >= SW'(RING_ENTRIES)) s = s - SW'(RING_ENTRIES);
    end
    return PW'(s);
  endfunction

  logic [CNT_W-1:0]   slot_count_r;
  logic               act_r;
  logic [ENTRY_W-1:0] ent_r;
  logic               inpool_r;
  logic               pres_r;
  logic               slot_ok_r;
  logic [SIW-1:0]     idx_r;
  logic               rd_vld_r;
  logic [2*PW-1:0]    rdata_r;

  logic [2*PW-1:0]    mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] vld_r;
  logic [PW-1:0]      rst_pos [MAX_SLOTS];

  logic [SIW-1:0]     in_idx;
  logic               in_slot_ok;
  logic [PW-1:0]      cur_a;
  logic [PW-1:0]      cur_f;
  logic [PW-1:0]      adv_a;
  logic [PW-1:0]      adv_f;
  logic [PW-1:0]      new_a;
  logic [PW-1:0]      new_f;
  logic               wr_en;
  status_t            status_c;
  logic [ENTRY_W-1:0] granted_c;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [ENTRY_W-1:0] out_granted_r;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_rst
    assign rst_pos[g] = PW'(g % RING_ENTRIES);
  end

  assign in_idx     = SIW'(in_slot);
  assign in_slot_ok = (32'(in_slot) < MAX_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= CNT_W'(1);
    end else if (cfg_we) begin
      slot_count_r <= cfg_wdata;
    end
  end

  // hold request fields for the execute cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_action;
      ent_r     <= in_entry_index;
      inpool_r  <= in_in_pool;
      pres_r    <= in_present;
      slot_ok_r <= in_slot_ok;
      idx_r     <= in_idx;
      rd_vld_r  <= vld_r[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[idx_r] <= {new_a, new_f};
    if (cmd.load) rdata_r <= mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  // unwritten entries read as their reset position
  assign cur_a = rd_vld_r ? rdata_r[2*PW-1:PW] : rst_pos[idx_r];
  assign cur_f = rd_vld_r ? rdata_r[PW-1:0]    : rst_pos[idx_r];
  assign adv_a = advance(cur_a, slot_count_r);
  assign adv_f = advance(cur_f, slot_count_r);

  always_comb begin
    status_c  = ST_NONE;
    granted_c = '0;
    new_a     = cur_a;
    new_f     = cur_f;
    wr_en     = 1'b0;
    if (slot_ok_r) begin
      if (act_r == ACT_ALLOC) begin
        if (adv_a == cur_f) begin
          status_c = ST_FULL;
        end else begin
          status_c  = ST_OK;
          granted_c = ENTRY_W'(cur_a);
          new_a     = adv_a;
          wr_en     = cmd.exec;
        end
      end else if (!pres_r) begin
        status_c = ST_NONE;
      end else if (!inpool_r) begin
        status_c = ST_HEAP;
      end else if (CW'(ent_r) == CW'(cur_f)) begin
        status_c = ST_OK;
        new_f    = adv_f;
        wr_en    = cmd.exec;
      end else begin
        status_c = ST_ORDER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r  <= status_c;
      out_granted_r <= granted_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_r;

endmodule

// ----- hw/rtl/interleaved_ring_slot_allocator_unit.sv -----
// Interleaved ring slot allocator.
// Request channel: start with in_action, in_slot, in_entry_index, in_in_pool
//   and in_present; a request is taken at a clock edge where start is high and
//   busy is low. Allocate requests grant the slot's next ring entry or report
//   full; free requests advance the slot's free position or report heap
//   release, out of order or nothing done.
// Result channel: out_valid pulses for one cycle with out_status and
//   out_granted_index. The receiver cannot stall; a result must be taken in
//   that cycle. Exactly one result per request.
// Config: cfg_we with cfg_wdata writes slot_count (the stride); write only
//   while idle. Positions keep their values across a write.
// Timing: the accepting edge registers the slot's positions, the next cycle
//   executes and writes them back, and out_valid is high in the cycle after
//   that; busy covers the execute cycle, so a new request is taken only once
//   the previous one has executed.
// Reset (rst_n low, synchronous): slot_count returns to 1, every slot's
//   positions read as the slot's own number, no request is pending and no
//   strobe is issued. No clearing pass is needed; valid bits cover it.
`include "assert_macros.svh"

module interleaved_ring_slot_allocator_unit #(
  parameter int RING_ENTRIES = 64,
  parameter int MAX_SLOTS    = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [irsa_pkg::SLOT_W-1:0]   in_slot,
  input  logic [irsa_pkg::ENTRY_W-1:0]  in_entry_index,
  input  logic                          in_in_pool,
  input  logic                          in_present,
  input  logic                          cfg_we,
  input  logic [irsa_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  output irsa_pkg::status_t             out_status,
  output logic [irsa_pkg::ENTRY_W-1:0]  out_granted_index
);
  import irsa_pkg::*;

  irsa_cmd_t cmd;

  // sequence each request: capture and read, then execute and write back
  irsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // position memory, stride register, update logic and result register
  irsa_dpath #(
    .RING_ENTRIES (RING_ENTRIES),
    .MAX_SLOTS    (MAX_SLOTS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_action),
    .in_slot           (in_slot),
    .in_entry_index    (in_entry_index),
    .in_in_pool        (in_in_pool),
    .in_present        (in_present),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index)
  );

  // every accepted request yields its strobe after the execute cycle
  `ASSERT_DELAY(a_req_to_result, clk, rst_n, start && !busy, 2, out_valid)
  // busy, once raised, is low again in the next cycle
  `ASSERT_NEXT(a_exec_one_cycle, clk, rst_n, busy, !busy)
  // the strobe is issued only after execute, with the controller idle
  `ASSERT_IMPLIES(a_strobe_idle, clk, rst_n, out_valid, !busy)
  // a grant index is carried only by a successful request
  `ASSERT_IMPLIES(a_grant_zero, clk, rst_n, out_valid && out_status != ST_OK, ~|out_granted_index)

endmodule
